// ----- design/rgb_to_hsv_converter_assert.svh -----
// Assertion macros shared by the checker files of the RGB to HSV converter.
// Users provide clk_i and rst_ni in the scope where a macro is expanded.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define HSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/hsv_pkg.sv -----
// Types and constants of the RGB to HSV converter.
// Used by every module of the block; depends on nothing.
package hsv_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 15;
  localparam int unsigned SatW    = 13;

  localparam logic [HueW-1:0] HueFull = 15'd23040;

  // Hue offsets in 1/64 degree for each sector and sign of the channel difference.
  localparam logic [HueW-1:0] HueBaseRedPos   = 15'd0;
  localparam logic [HueW-1:0] HueBaseRedNeg   = 15'd19200;
  localparam logic [HueW-1:0] HueBaseGreenPos = 15'd7680;
  localparam logic [HueW-1:0] HueBaseGreenNeg = 15'd3840;
  localparam logic [HueW-1:0] HueBaseBluePos  = 15'd15360;
  localparam logic [HueW-1:0] HueBaseBlueNeg  = 15'd11520;

  // Pipelined restoring divider.
  localparam int unsigned DivNumW   = 22;
  localparam int unsigned DivDenW   = ChanW + 1;
  localparam int unsigned DivRemW   = DivDenW;
  localparam int unsigned DivQuoW   = 13;
  localparam int unsigned DivSteps  = 2;
  localparam int unsigned DivStages = (DivQuoW + DivSteps - 1) / DivSteps;
  localparam int unsigned DivLanes  = 2;
  localparam int unsigned LaneHue   = 0;
  localparam int unsigned LaneSat   = 1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [HueW-1:0]  base;
    logic             gray;
    logic             black;
    logic [ChanW-1:0] bright;
  } side_t;

  typedef logic [DivLanes-1:0][DivNumW-1:0] num_vec_t;
  typedef logic [DivLanes-1:0][DivDenW-1:0] den_vec_t;
  typedef logic [DivLanes-1:0][DivQuoW-1:0] quo_vec_t;
  typedef logic [DivLanes-1:0][DivRemW-1:0] rem_vec_t;

endpackage

// ----- design/hsv_if.sv -----
// Valid/ready channel interfaces for pixels in and HSV results out.
// Depends on nothing but the field widths of the converter.
interface hsv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hsv_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [12:0] saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness, output ready);
endinterface

// ----- design/hsv_front.sv -----
// Front end: extremes and sector in one stage, divider operands in the next.
// Depends on hsv_pkg.
module hsv_front import hsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  pix_t     pix_i,
  output logic     valid_o,
  output num_vec_t num_o,
  output den_vec_t den_o,
  output side_t    side_o
);

  logic             s1_valid_q;
  logic [ChanW-1:0] mx_d, mx_q, mn_d, mn_q;
  logic             red_max_d, red_max_q, green_max_d, green_max_q;
  pix_t             pix_q;

  logic [ChanW-1:0] delta;
  logic [ChanW-1:0] frac;
  logic [HueW-1:0]  base;
  num_vec_t         num_d, num_q;
  den_vec_t         den_d, den_q;
  side_t            side_d, side_q;
  logic             s2_valid_q;

  always_comb begin
    mx_d = pix_i.red;
    mn_d = pix_i.red;
    if (pix_i.green > mx_d) mx_d = pix_i.green;
    if (pix_i.blue > mx_d) mx_d = pix_i.blue;
    if (pix_i.green < mn_d) mn_d = pix_i.green;
    if (pix_i.blue < mn_d) mn_d = pix_i.blue;
    red_max_d   = (mx_d == pix_i.red);
    green_max_d = (mx_d == pix_i.green);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mx_q        <= mx_d;
      mn_q        <= mn_d;
      red_max_q   <= red_max_d;
      green_max_q <= green_max_d;
      pix_q       <= pix_i;
    end
  end

  // The hue fraction is always taken non-negative against a shifted sector base.
  always_comb begin
    delta = mx_q - mn_q;
    priority if (red_max_q) begin
      if (pix_q.green >= pix_q.blue) begin
        frac = pix_q.green - pix_q.blue;
        base = HueBaseRedPos;
      end else begin
        frac = mx_q - pix_q.blue;
        base = HueBaseRedNeg;
      end
    end else if (green_max_q) begin
      if (pix_q.blue >= pix_q.red) begin
        frac = pix_q.blue - pix_q.red;
        base = HueBaseGreenPos;
      end else begin
        frac = mx_q - pix_q.red;
        base = HueBaseGreenNeg;
      end
    end else begin
      if (pix_q.red >= pix_q.green) begin
        frac = pix_q.red - pix_q.green;
        base = HueBaseBluePos;
      end else begin
        frac = mx_q - pix_q.green;
        base = HueBaseBlueNeg;
      end
    end

    num_d[LaneHue] = (DivNumW'(frac) << 13) - (DivNumW'(frac) << 9) + DivNumW'(delta);
    den_d[LaneHue] = {delta, 1'b0};
    num_d[LaneSat] = (DivNumW'(delta) << 13) + DivNumW'(mx_q);
    den_d[LaneSat] = {mx_q, 1'b0};

    side_d.base   = base;
    side_d.gray   = (delta == '0);
    side_d.black  = (mx_q == '0);
    side_d.bright = mx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

// ----- design/hsv_div.sv -----
// Pipelined restoring divider with one lane for hue and one for saturation.
// Each stage resolves a few quotient bits; depends on hsv_pkg.
module hsv_div import hsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  num_vec_t num_i,
  input  den_vec_t den_i,
  input  side_t    side_i,
  output logic     valid_o,
  output quo_vec_t quo_o,
  output side_t    side_o
);

  logic     valid_q [DivStages];
  rem_vec_t rem_q   [DivStages];
  quo_vec_t low_q   [DivStages];
  den_vec_t den_q   [DivStages];
  side_t    side_q  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic     valid_in;
    rem_vec_t rem_in, rem_d;
    quo_vec_t low_in, low_d;
    den_vec_t den_in;
    side_t    side_in;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign den_in   = den_i;
      assign side_in  = side_i;
      for (genvar l = 0; l < DivLanes; l++) begin : g_lane
        assign rem_in[l] = num_i[l][DivNumW-1:DivQuoW];
        assign low_in[l] = num_i[l][DivQuoW-1:0];
      end
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign low_in   = low_q[s-1];
      assign den_in   = den_q[s-1];
      assign side_in  = side_q[s-1];
    end

    always_comb begin
      logic [DivRemW:0] trial;
      rem_d = rem_in;
      low_d = low_in;
      for (int l = 0; l < DivLanes; l++) begin
        for (int j = 0; j < DivSteps; j++) begin
          if (s * DivSteps + j < DivQuoW) begin
            trial = {rem_d[l], low_d[l][DivQuoW-1]};
            if (trial >= {1'b0, den_in[l]}) begin
              rem_d[l] = DivRemW'(trial - {1'b0, den_in[l]});
              low_d[l] = {low_d[l][DivQuoW-2:0], 1'b1};
            end else begin
              rem_d[l] = trial[DivRemW-1:0];
              low_d[l] = {low_d[l][DivQuoW-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        low_q[s]  <= low_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[DivStages-1];
  assign quo_o   = low_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule

// ----- design/hsv_back.sv -----
// Back end: adds the sector base, wraps the full circle and applies the
// gray and black cases into the output register. Depends on hsv_pkg.
module hsv_back import hsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  quo_vec_t quo_i,
  input  side_t    side_i,
  output logic     valid_o,
  output hsv_t     res_o
);

  logic            valid_q;
  hsv_t            res_d, res_q;
  logic [HueW-1:0] hue_sum;

  always_comb begin
    hue_sum = side_i.base + HueW'(quo_i[LaneHue]);
    if (side_i.gray) begin
      res_d.hue = '0;
    end else if (hue_sum >= HueFull) begin
      res_d.hue = hue_sum - HueFull;
    end else begin
      res_d.hue = hue_sum;
    end
    res_d.saturation = side_i.black ? '0 : quo_i[LaneSat];
    res_d.brightness = side_i.bright;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- design/rgb_to_hsv_converter.sv -----
// Top level of the RGB to HSV converter: front end, divider pipeline, back end.
// Depends on hsv_pkg, hsv_if, hsv_front, hsv_div and hsv_back.
//
//   Channel   Direction  Fields                          Beat
//   pix_i     in         red, green, blue (8 b each)     one pixel
//   hsv_o     out        hue 15 b, saturation 13 b,      one result per pixel
//                        brightness 8 b
//
// One pixel is taken every cycle unless a result waits at the output; the
// divider between front and back end resolves two quotient bits per stage.
// All stages advance together; when a result waits, the whole pipeline holds.
// Reset clears only the valid bits; no state survives between pixels.
module rgb_to_hsv_converter import hsv_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  hsv_pix_if.sink        pix_i,
  hsv_res_if.source      hsv_o
);

  logic     adv;
  pix_t     pix;
  logic     front_valid, div_valid, back_valid;
  num_vec_t num;
  den_vec_t den;
  side_t    front_side, div_side;
  quo_vec_t quo;
  hsv_t     res;

  assign adv         = !back_valid || hsv_o.ready;
  assign pix_i.ready = adv;
  assign pix.red     = pix_i.red;
  assign pix.green   = pix_i.green;
  assign pix.blue    = pix_i.blue;

  hsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (pix_i.valid),
    .pix_i   (pix),
    .valid_o (front_valid),
    .num_o   (num),
    .den_o   (den),
    .side_o  (front_side)
  );

  hsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .num_i   (num),
    .den_i   (den),
    .side_i  (front_side),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  hsv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_valid),
    .quo_i   (quo),
    .side_i  (div_side),
    .valid_o (back_valid),
    .res_o   (res)
  );

  assign hsv_o.valid      = back_valid;
  assign hsv_o.hue        = res.hue;
  assign hsv_o.saturation = res.saturation;
  assign hsv_o.brightness = res.brightness;

endmodule

// ----- design/hsv_checker.sv -----
// Port-level checker of the RGB to HSV converter and its bind to the top level.
// Depends on hsv_pkg and rgb_to_hsv_converter_assert.svh.
`include "rgb_to_hsv_converter_assert.svh"

module hsv_checker import hsv_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [HueW-1:0] hue_i,
  input logic [SatW-1:0] sat_i,
  input logic [ChanW-1:0] bright_i
);

  `HSV_ASSERT_RST(a_idle_after_reset, !rst_ni |=> !out_valid_i, "result beat right after reset")
  `HSV_ASSERT(a_hold_stalled, out_valid_i && !out_ready_i |=> out_valid_i && $stable(hue_i) && $stable(sat_i) && $stable(bright_i), "stalled result beat changed")
  `HSV_ASSERT(a_stall_blocks_input, out_valid_i && !out_ready_i |-> !in_ready_i, "pixel taken while result stalled")
  `HSV_ASSERT(a_ranges, out_valid_i |-> hue_i < HueFull && sat_i <= SatW'(4096), "result out of range")
  `HSV_ASSERT(a_gray_hue, out_valid_i && (sat_i == '0 || bright_i == '0) |-> hue_i == '0 && sat_i == '0, "gray pixel with nonzero hue")

endmodule

bind rgb_to_hsv_converter hsv_checker u_hsv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (hsv_o.valid),
  .out_ready_i (hsv_o.ready),
  .hue_i       (hsv_o.hue),
  .sat_i       (hsv_o.saturation),
  .bright_i    (hsv_o.brightness)
);

// ----- tb/hsv_converter_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the RGB to HSV converter: watches both channels, predicts each result.
// Depends on hsv_pkg and the pixel and result interfaces of the converter.
module hsv_converter_checker import hsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsv_pix_if          pix_i,
  hsv_res_if          hsv_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam logic [31:0] HueSixty = 32'd3840;
  localparam logic [31:0] SatScale = 32'd4096;

  typedef struct packed {
    pix_t px;
    hsv_t hsv;
  } hsv_due_t;

  hsv_due_t    hsv_due_q[$];
  int unsigned mismatch_cnt;

  function automatic hsv_t predict_hsv(pix_t px);
    logic [31:0] r, g, b, mx, mn, delta, num, hue, sat;
    hsv_t        res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = '0;
    sat = '0;
    if (delta != 0) begin
      if (mx == r) begin
        if (g >= b) begin
          num = HueSixty * (g - b);
        end else begin
          num = 32'(HueFull) * delta - HueSixty * (b - g);
        end
      end else if (mx == g) begin
        num = 2 * HueSixty * delta + HueSixty * b - HueSixty * r;
      end else begin
        num = 4 * HueSixty * delta + HueSixty * r - HueSixty * g;
      end
      hue = (2 * num + delta) / (2 * delta);
      if (hue >= 32'(HueFull)) hue = hue - 32'(HueFull);
    end
    if (mx != 0) sat = (2 * SatScale * delta + mx) / (2 * mx);
    res.hue        = hue[HueW-1:0];
    res.saturation = sat[SatW-1:0];
    res.brightness = mx[ChanW-1:0];
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    hsv_due_t due;
    hsv_t     seen;
    pix_t     px;
    if (!rst_ni) begin
      hsv_due_q.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (pix_i.valid && pix_i.ready) begin
        px.red   = pix_i.red;
        px.green = pix_i.green;
        px.blue  = pix_i.blue;
        due.px   = px;
        due.hsv  = predict_hsv(px);
        hsv_due_q.push_back(due);
      end
      if (hsv_i.valid && hsv_i.ready) begin
        seen.hue        = hsv_i.hue;
        seen.saturation = hsv_i.saturation;
        seen.brightness = hsv_i.brightness;
        if (hsv_due_q.size() == 0) begin
          note_mismatch($sformatf("unexpected beat hue=%0d sat=%0d val=%0d",
                                  seen.hue, seen.saturation, seen.brightness));
        end else begin
          due = hsv_due_q.pop_front();
          checked_o <= checked_o + 1;
          if (seen.hue !== due.hsv.hue || seen.saturation !== due.hsv.saturation ||
              seen.brightness !== due.hsv.brightness) begin
            note_mismatch($sformatf(
              "rgb=(%0d,%0d,%0d) hue %0d/%0d sat %0d/%0d val %0d/%0d (expected/actual)",
              due.px.red, due.px.green, due.px.blue, due.hsv.hue, seen.hue,
              due.hsv.saturation, seen.saturation, due.hsv.brightness, seen.brightness));
          end
        end
      end
      mismatches_o <= mismatch_cnt;
      pending_o    <= hsv_due_q.size();
    end
  end

endmodule

// ----- tb/tb_rgb_to_hsv_converter.sv -----
`timescale 1ns / 100ps
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus and verdict.
// Depends on hsv_pkg, the converter's interfaces, the converter and hsv_converter_checker.
module tb_rgb_to_hsv_converter;

  localparam int unsigned RandomPixels = 800;
  localparam int unsigned DrainCycles  = 30;
  localparam realtime     RunLimit     = 5ms;

  typedef enum int {PixUniform, PixTie, PixGray, PixDim, PixSaturated, PixExtreme} pix_kind_e;
  typedef enum int {RdyAlways, RdyCoin, RdyMostly, RdyStall} rdy_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned directed_cnt;
  int unsigned random_cnt;

  hsv_pix_if pix_bus ();
  hsv_res_if hsv_bus ();

  rgb_to_hsv_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .hsv_o  (hsv_bus)
  );

  hsv_converter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_bus),
    .hsv_i        (hsv_bus),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimit);
    $display("Timed out with %0d results outstanding.", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    @(negedge clk_i);
    pix_bus.valid <= 1'b1;
    pix_bus.red   <= r;
    pix_bus.green <= g;
    pix_bus.blue  <= b;
    do @(posedge clk_i); while (!pix_bus.ready);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      pix_bus.valid <= 1'b0;
      pix_bus.red   <= 8'($urandom);
      pix_bus.green <= 8'($urandom);
      pix_bus.blue  <= 8'($urandom);
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] extreme_byte();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  task automatic send_random();
    logic [7:0] r, g, b;
    pix_kind_e  kind;
    case ($urandom_range(0, 9))
      5:       kind = PixTie;
      6:       kind = PixGray;
      7:       kind = PixDim;
      8:       kind = PixSaturated;
      9:       kind = PixExtreme;
      default: kind = PixUniform;
    endcase
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case (kind)
      PixTie: begin
        case ($urandom_range(0, 2))
          0:       g = r;
          1:       b = g;
          default: b = r;
        endcase
      end
      PixGray: begin
        g = r;
        b = r;
      end
      PixDim: begin
        r = 8'($urandom_range(0, 3));
        g = 8'($urandom_range(0, 3));
        b = 8'($urandom_range(0, 3));
      end
      PixSaturated: begin
        case ($urandom_range(0, 2))
          0:       r = 8'd255;
          1:       g = 8'd255;
          default: b = 8'd255;
        endcase
      end
      PixExtreme: begin
        r = extreme_byte();
        g = extreme_byte();
        b = extreme_byte();
      end
      default: ;
    endcase
    send_rgb(r, g, b);
  endtask

  initial begin : result_sink
    int unsigned stretch, hold;
    rdy_mode_e   mode;
    hsv_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode    = rdy_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(16, 96);
      hold    = 0;
      repeat (stretch) begin
        @(negedge clk_i);
        case (mode)
          RdyAlways: hsv_bus.ready <= 1'b1;
          RdyCoin:   hsv_bus.ready <= 1'($urandom_range(0, 1));
          RdyMostly: hsv_bus.ready <= ($urandom_range(0, 9) != 0);
          default: begin
            if (hold != 0) begin
              hold--;
              hsv_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
              hold = $urandom_range(4, 24);
              hsv_bus.ready <= 1'b0;
            end else begin
              hsv_bus.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin : pixel_source
    int unsigned burst;
    pix_bus.valid = 1'b0;
    pix_bus.red   = 8'd0;
    pix_bus.green = 8'd0;
    pix_bus.blue  = 8'd0;
    rst_ni        = 1'b0;
    directed_cnt  = 0;
    random_cnt    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Black, white, gray, primaries, tied maxima, wrapping red hues, tiny and edge values.
    send_rgb(8'd0, 8'd0, 8'd0);
    send_rgb(8'd255, 8'd255, 8'd255);
    send_rgb(8'd128, 8'd128, 8'd128);
    send_rgb(8'd1, 8'd1, 8'd1);
    send_rgb(8'd255, 8'd0, 8'd0);
    send_rgb(8'd0, 8'd255, 8'd0);
    send_rgb(8'd0, 8'd0, 8'd255);
    send_rgb(8'd255, 8'd255, 8'd0);
    send_rgb(8'd0, 8'd255, 8'd255);
    send_rgb(8'd255, 8'd0, 8'd255);
    send_rgb(8'd255, 8'd0, 8'd1);
    send_rgb(8'd255, 8'd1, 8'd0);
    send_rgb(8'd200, 8'd10, 8'd50);
    send_rgb(8'd10, 8'd200, 8'd50);
    send_rgb(8'd50, 8'd10, 8'd200);
    send_rgb(8'd1, 8'd0, 8'd0);
    send_rgb(8'd0, 8'd1, 8'd0);
    send_rgb(8'd0, 8'd0, 8'd1);
    send_rgb(8'd255, 8'd254, 8'd254);
    send_rgb(8'd254, 8'd255, 8'd255);
    send_rgb(8'd170, 8'd85, 8'd0);
    send_rgb(8'd3, 8'd2, 8'd0);
    send_rgb(8'hAA, 8'h55, 8'hFF);
    send_rgb(8'h55, 8'hAA, 8'h00);
    directed_cnt = 24;
    wait_drained();

    while (random_cnt < RandomPixels) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random();
        random_cnt++;
        if (random_cnt == RandomPixels / 2) wait_drained();
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d pixels (%0d directed, %0d random) under bursty input and stalled output.",
             directed_cnt + random_cnt, directed_cnt, random_cnt);
    $display("Checked %0d HSV results; %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived.", pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
